// ----- src/rtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

    // Field and datapath widths.
    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int RATE_W     = 31;
    localparam int PROD_W     = 63;
    localparam int DIST_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 104;

    // Products are clamped at 2^62.
    localparam logic [PROD_W-1:0] PROD_CAP = {1'b1, {(PROD_W-1){1'b0}}};

    localparam logic signed [DIST_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_POS,
        CFG_END_POS,
        CFG_VEL_MAX,
        CFG_ACCEL,
        CFG_ACCEL_TIME,
        CFG_CRUISE_TIME,
        CFG_TIME_STEP
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_WAIT,
        ST_FINAL,
        ST_HALT
    } state_t;

    // Multiply steps of one tick, in issue order.
    typedef enum logic [2:0] {
        STEP_RAMP_RATE,
        STEP_RAMP_DIST,
        STEP_CRUISE_DIST,
        STEP_COAST_DIST,
        STEP_BRAKE_RATE,
        STEP_BRAKE_DIST
    } step_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    function automatic logic [PROD_W-1:0] add_cap(input logic [PROD_W-1:0] a,
                                                  input logic [PROD_W-1:0] b);
        logic [PROD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, PROD_CAP}) begin
            return PROD_CAP;
        end
        return s[PROD_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat32(input logic signed [DIST_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[POS_W-1:0];
        end
        if (v < SAT_LO) begin
            return SAT_LO[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/rtp_serial_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one bit of the time operand per cycle, LSB first.
// The low product bits shift into the time register as it empties.
module rtp_serial_mul import rtp_pkg::*; #(
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] x,
    input  wire logic [TIME_W-1:0] m,
    output mul_status_t            status,
    output logic [PROD_W-1:0]      result
);

    localparam int PW = PROD_W + TIME_W;
    localparam int QW = PW - TIME_FRAC_BITS;
    localparam int CW = $clog2(TIME_W);
    localparam logic [QW-1:0] CAP_Q = QW'(PROD_CAP);
    localparam logic [CW-1:0] LAST_BIT = CW'(TIME_W - 1);

    logic [PROD_W-1:0] x_reg, x_next;
    logic [TIME_W-1:0] m_reg, m_next;
    logic [PROD_W:0]   hi_reg, hi_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [PROD_W:0]   addend;
    logic [PROD_W:0]   sum;
    logic [PW-1:0]     product;
    logic [QW-1:0]     q;

    always_comb begin
        addend    = m_reg[0] ? {1'b0, x_reg} : '0;
        sum       = hi_reg + addend;
        x_next    = x_reg;
        m_next    = m_reg;
        hi_next   = hi_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x;
            m_next    = m;
            hi_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = {1'b0, sum[PROD_W:1]};
            m_next   = {sum[0], m_reg[TIME_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg  <= x_next;
        m_reg  <= m_next;
        hi_reg <= hi_next;
    end

    always_comb begin
        product = {hi_reg[PROD_W-1:0], m_reg};
        q       = product[PW-1:TIME_FRAC_BITS];
        result  = (q > CAP_Q) ? PROD_CAP : q[PROD_W-1:0];
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ----- src/reciprocating_trapezoid_profile_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Reciprocating trapezoidal profile generator for one joint.
// Each item on the s_ channel is one control tick; bit 0 of s_tdata flags an
// obstacle. Each tick returns exactly one item on the m_ channel with the
// reference position, velocity, acceleration, phase, direction and halt flag.
// The user must write the profile parameters through cfg_wr_en/cfg_index/
// cfg_wdata only while the block is idle; the block itself does not enforce
// this. The configuration registers reset to zero. One shared serial
// multiplier retires one bit of the time operand per cycle. A tick needs
// 2, 3 or 6 multiplies (accelerate, cruise, decelerate) and a halted tick
// none; a new tick is taken only once the last has left the final step.
// The output register holds a result until m_tready; a new tick is accepted
// meanwhile, and its result waits in the final step until the register frees.
// Reset is synchronous and active low; it clears the time, direction, held
// position, halt latch and configuration, and empties the output register.
module reciprocating_trapezoid_profile_core import rtp_pkg::*; #(
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: [0] obstacle, rest zero
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: [31:0] ref_position, [63:32] ref_velocity, [95:64] ref_accel,
    // [97:96] phase, [98] moving_down, [99] halted, rest zero
    output logic [M_DATA_W-1:0]        m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [POS_W-1:0]  start_pos_reg, start_pos_next;
    logic [POS_W-1:0]  end_pos_reg, end_pos_next;
    logic [RATE_W-1:0] vmax_reg, vmax_next;
    logic [RATE_W-1:0] acc_reg, acc_next;
    logic [TIME_W-1:0] ta_reg, ta_next;
    logic [TIME_W-1:0] tc_reg, tc_next;
    logic [TIME_W-1:0] dt_reg, dt_next;

    // Profile state.
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic              down_reg, down_next;
    logic [POS_W-1:0]  held_reg, held_next;
    logic              stopped_reg, stopped_next;

    // Sequencer and working registers.
    state_t                    state_reg, state_next;
    step_t                     step_reg, step_next;
    phase_t                    ph_reg, ph_next;
    logic [TIME_W-1:0]         t_reg, t_next;
    logic [TIME_W-1:0]         td_reg, td_next;
    logic                      turn_reg, turn_next;
    logic [PROD_W-1:0]         p_reg, p_next;
    logic signed [DIST_W-1:0]  dist_reg, dist_next;
    logic signed [DIST_W-1:0]  vel_reg, vel_next;

    // Output register.
    logic                      m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;

    // Multiplier interface.
    logic                      mul_start;
    logic [PROD_W-1:0]         mul_x;
    logic [TIME_W-1:0]         mul_m;
    mul_status_t               mul_status;
    logic [PROD_W-1:0]         mul_result;

    rtp_serial_mul #(
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .x      (mul_x),
        .m      (mul_m),
        .status (mul_status),
        .result (mul_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic              out_free;
        logic [TIME_W:0]   t_sum;
        logic [TIME_W:0]   ac_sum;
        logic [TIME_W+1:0] total;
        logic              last_step;
        logic [TIME_W-1:0] th;
        logic signed [DIST_W-1:0] q_zero;
        logic signed [DIST_W-1:0] pos_sum;
        logic signed [DIST_W-1:0] vel_dir;
        logic [POS_W-1:0]  pos_out;
        logic [POS_W-1:0]  acc_mag;
        logic [POS_W-1:0]  acc_out;
        logic              acc_plus;

        start_pos_next = start_pos_reg;
        end_pos_next   = end_pos_reg;
        vmax_next      = vmax_reg;
        acc_next       = acc_reg;
        ta_next        = ta_reg;
        tc_next        = tc_reg;
        dt_next        = dt_reg;
        elapsed_next   = elapsed_reg;
        down_next      = down_reg;
        held_next      = held_reg;
        stopped_next   = stopped_reg;
        state_next     = state_reg;
        step_next      = step_reg;
        ph_next        = ph_reg;
        t_next         = t_reg;
        td_next        = td_reg;
        turn_next      = turn_reg;
        p_next         = p_reg;
        dist_next      = dist_reg;
        vel_next       = vel_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_free       = !m_valid_reg || m_tready;
        mul_start      = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_POS:   start_pos_next = cfg_wdata;
                CFG_END_POS:     end_pos_next   = cfg_wdata;
                CFG_VEL_MAX:     vmax_next      = cfg_wdata[RATE_W-1:0];
                CFG_ACCEL:       acc_next       = cfg_wdata[RATE_W-1:0];
                CFG_ACCEL_TIME:  ta_next        = cfg_wdata;
                CFG_CRUISE_TIME: tc_next        = cfg_wdata;
                CFG_TIME_STEP:   dt_next        = cfg_wdata;
                default: ;
            endcase
        end

        t_sum  = {1'b0, elapsed_reg} + {1'b0, dt_reg};
        ac_sum = {1'b0, ta_reg} + {1'b0, tc_reg};
        total  = {1'b0, ta_reg, 1'b0} + {2'b00, tc_reg};

        // Time used by the half-square term: the tick time while ramping up,
        // the full ramp time once past it.
        th = (ph_reg == PH_ACCEL) ? t_reg : ta_reg;

        unique case (step_reg)
            STEP_RAMP_RATE: begin
                mul_x = PROD_W'(acc_reg);
                mul_m = th;
            end
            STEP_RAMP_DIST: begin
                mul_x = p_reg;
                mul_m = th;
            end
            STEP_CRUISE_DIST: begin
                mul_x = PROD_W'(vmax_reg);
                mul_m = (ph_reg == PH_CRUISE) ? td_reg : tc_reg;
            end
            STEP_COAST_DIST: begin
                mul_x = PROD_W'(vmax_reg);
                mul_m = td_reg;
            end
            STEP_BRAKE_RATE: begin
                mul_x = PROD_W'(acc_reg);
                mul_m = td_reg;
            end
            STEP_BRAKE_DIST: begin
                mul_x = p_reg;
                mul_m = td_reg;
            end
            default: begin
                mul_x = '0;
                mul_m = '0;
            end
        endcase

        last_step = ((ph_reg == PH_ACCEL) && (step_reg == STEP_RAMP_DIST)) ||
                    ((ph_reg == PH_CRUISE) && (step_reg == STEP_CRUISE_DIST)) ||
                    (step_reg == STEP_BRAKE_DIST);

        // Final combine: direction, endpoint offset and saturation.
        q_zero  = down_reg ? DIST_W'(signed'(end_pos_reg)) : DIST_W'(signed'(start_pos_reg));
        pos_sum = down_reg ? (q_zero - dist_reg) : (q_zero + dist_reg);
        vel_dir = down_reg ? -vel_reg : vel_reg;
        pos_out = sat32(pos_sum);
        if (turn_reg) begin
            pos_out = down_reg ? start_pos_reg : end_pos_reg;
        end
        acc_mag  = {1'b0, acc_reg};
        acc_plus = ((ph_reg == PH_ACCEL) && !down_reg) || ((ph_reg == PH_DECEL) && down_reg);
        if (ph_reg == PH_CRUISE) begin
            acc_out = '0;
        end else if (acc_plus) begin
            acc_out = acc_mag;
        end else begin
            acc_out = -acc_mag;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0] || stopped_reg) begin
                        stopped_next = 1'b1;
                        state_next   = ST_HALT;
                    end else begin
                        t_next     = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                step_next = STEP_RAMP_RATE;
                vel_next  = DIST_W'(vmax_reg);
                turn_next = 1'b0;
                if (t_reg <= ta_reg) begin
                    ph_next = PH_ACCEL;
                    td_next = '0;
                end else if ({1'b0, t_reg} <= ac_sum) begin
                    ph_next = PH_CRUISE;
                    td_next = t_reg - ta_reg;
                end else begin
                    ph_next   = PH_DECEL;
                    td_next   = t_reg - ac_sum[TIME_W-1:0];
                    turn_next = ({2'b00, t_reg} >= total);
                end
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (!mul_status.busy) begin
                    mul_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mul_status.done) begin
                    unique case (step_reg)
                        STEP_RAMP_RATE: begin
                            p_next = mul_result;
                            if (ph_reg == PH_ACCEL) begin
                                vel_next = DIST_W'(mul_result);
                            end
                        end
                        STEP_RAMP_DIST: begin
                            dist_next = {2'b00, mul_result[PROD_W-1:1]};
                        end
                        STEP_CRUISE_DIST, STEP_COAST_DIST: begin
                            dist_next = {1'b0, add_cap(dist_reg[PROD_W-1:0], mul_result)};
                        end
                        STEP_BRAKE_RATE: begin
                            p_next   = mul_result;
                            vel_next = DIST_W'(vmax_reg) - DIST_W'(mul_result);
                        end
                        STEP_BRAKE_DIST: begin
                            dist_next = dist_reg - {2'b00, mul_result[PROD_W-1:1]};
                        end
                        default: ;
                    endcase
                    if (last_step) begin
                        state_next = ST_FINAL;
                    end else begin
                        step_next  = step_t'(step_reg + 3'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, 1'b0, down_reg ^ turn_reg, ph_reg,
                                    acc_out, sat32(vel_dir), pos_out};
                    held_next    = pos_out;
                    if (turn_reg) begin
                        elapsed_next = '0;
                        down_next    = !down_reg;
                    end else begin
                        elapsed_next = t_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_HALT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, 1'b1, down_reg, PH_HALT,
                                    {POS_W{1'b0}}, {POS_W{1'b0}}, held_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg <= '0;
            end_pos_reg   <= '0;
            vmax_reg      <= '0;
            acc_reg       <= '0;
            ta_reg        <= '0;
            tc_reg        <= '0;
            dt_reg        <= '0;
            elapsed_reg   <= '0;
            down_reg      <= 1'b0;
            held_reg      <= '0;
            stopped_reg   <= 1'b0;
            step_reg      <= STEP_RAMP_RATE;
            m_valid_reg   <= 1'b0;
        end else begin
            start_pos_reg <= start_pos_next;
            end_pos_reg   <= end_pos_next;
            vmax_reg      <= vmax_next;
            acc_reg       <= acc_next;
            ta_reg        <= ta_next;
            tc_reg        <= tc_next;
            dt_reg        <= dt_next;
            elapsed_reg   <= elapsed_next;
            down_reg      <= down_next;
            held_reg      <= held_next;
            stopped_reg   <= stopped_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Working values and the output payload need no reset.
    always_ff @(posedge aclk) begin
        ph_reg     <= ph_next;
        t_reg      <= t_next;
        td_reg     <= td_next;
        turn_reg   <= turn_next;
        p_reg      <= p_next;
        dist_reg   <= dist_next;
        vel_reg    <= vel_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ----- tb/reciprocating_trapezoid_profile_core_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the reciprocating trapezoid profile core.
module reciprocating_trapezoid_profile_core_tb;
    import rtp_pkg::*;

    // Time fraction bits used by the block and by the profile predictor.
    localparam int TFRAC = 16;

    // About 25 directed items come first, then roughly this many random ones.
    localparam int RANDOM_ITEMS = 1900;

    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 3000;

    // One expected or observed tick result, in the order of the m_tdata fields.
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] accel;
        phase_t      phase;
        logic        moving_down;
        logic        halted;
    } tick_result_t;

    // The scoreboard carries its own copy of the profile registers and of the
    // generator state. Each accepted tick is run through the profile math at
    // once and the outcome waits in a queue until the block returns its item.
    class profile_scoreboard;
        logic signed [31:0] start_pos;
        logic signed [31:0] end_pos;
        logic [30:0]        vmax;
        logic [30:0]        acc;
        logic [31:0]        ta;
        logic [31:0]        tc;
        logic [31:0]        dt;

        logic [31:0]        t_elapsed;
        bit                 going_down;
        logic [31:0]        last_pos;
        bit                 latched_halt;

        tick_result_t       expected_q[$];
        int                 mismatches;

        function new();
            start_pos    = '0;
            end_pos      = '0;
            vmax         = '0;
            acc          = '0;
            ta           = '0;
            tc           = '0;
            dt           = '0;
            t_elapsed    = '0;
            going_down   = 1'b0;
            last_pos     = '0;
            latched_halt = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_START_POS:   start_pos = value;
                CFG_END_POS:     end_pos   = value;
                CFG_VEL_MAX:     vmax      = value[30:0];
                CFG_ACCEL:       acc       = value[30:0];
                CFG_ACCEL_TIME:  ta        = value;
                CFG_CRUISE_TIME: tc        = value;
                CFG_TIME_STEP:   dt        = value;
                default: ;
            endcase
        endfunction

        // Rate or distance times a time: the product is shifted down by the
        // time fraction and clamped at 2^62.
        function logic [62:0] scale_by_time(logic [62:0] x, logic [31:0] t);
            logic [94:0] p;
            p = {32'b0, x} * {63'b0, t};
            p = p >> TFRAC;
            if (p > {32'b0, PROD_CAP}) begin
                return PROD_CAP;
            end
            return p[62:0];
        endfunction

        // Distance covered while ramping for a time t: half of accel * t * t.
        function logic [62:0] ramp_distance(logic [31:0] t);
            return scale_by_time(scale_by_time({32'b0, acc}, t), t) >> 1;
        endfunction

        function logic [62:0] sum_capped(logic [62:0] a, logic [62:0] b);
            logic [63:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s > {1'b0, PROD_CAP}) begin
                return PROD_CAP;
            end
            return s[62:0];
        endfunction

        function logic [31:0] clamp32(longint v);
            if (v > 64'sh0000_0000_7FFF_FFFF) begin
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sh0000_0000_8000_0000) begin
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        // Works out the result of one accepted tick and queues it.
        function void note_tick(bit obstacle);
            logic [32:0]  t_sum;
            logic [31:0]  t;
            logic [32:0]  knee;
            logic [33:0]  total;
            logic [31:0]  td;
            logic [62:0]  up;
            longint       base;
            longint       travel;
            longint       vel;
            longint       acc_out;
            logic [31:0]  pos;
            phase_t       ph;
            tick_result_t r;

            if (obstacle) begin
                latched_halt = 1'b1;
            end
            if (latched_halt) begin
                r = '{last_pos, 32'b0, 32'b0, PH_HALT, going_down, 1'b1};
                expected_q.push_back(r);
                return;
            end

            // Elapsed time saturates instead of wrapping.
            t_sum = {1'b0, t_elapsed} + {1'b0, dt};
            t = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
            t_elapsed = t;

            knee  = {1'b0, ta} + {1'b0, tc};
            total = {2'b0, ta} + {2'b0, ta} + {2'b0, tc};
            base  = going_down ? longint'(end_pos) : longint'(start_pos);

            if (t <= ta) begin
                ph      = PH_ACCEL;
                acc_out = longint'(acc);
                vel     = longint'(scale_by_time({32'b0, acc}, t));
                travel  = longint'(ramp_distance(t));
            end else if ({1'b0, t} <= knee) begin
                ph      = PH_CRUISE;
                acc_out = 0;
                vel     = longint'(vmax);
                travel  = longint'(sum_capped(ramp_distance(ta),
                                              scale_by_time({32'b0, vmax}, t - ta)));
            end else begin
                // Braking goes on past the velocity zero crossing unchanged.
                td      = t - knee[31:0];
                up      = sum_capped(ramp_distance(ta), scale_by_time({32'b0, vmax}, tc));
                up      = sum_capped(up, scale_by_time({32'b0, vmax}, td));
                ph      = PH_DECEL;
                acc_out = -longint'(acc);
                vel     = longint'(vmax) - longint'(scale_by_time({32'b0, acc}, td));
                travel  = longint'(up) - longint'(ramp_distance(td));
            end

            if (going_down) begin
                travel  = -travel;
                vel     = -vel;
                acc_out = -acc_out;
            end
            pos = clamp32(base + travel);
            vel = longint'($signed(clamp32(vel)));

            // Turnaround: snap to the endpoint just reached and reverse.
            if (ph == PH_DECEL && {2'b0, t} >= total) begin
                t_elapsed = '0;
                if (going_down) begin
                    pos        = start_pos;
                    going_down = 1'b0;
                end else begin
                    pos        = end_pos;
                    going_down = 1'b1;
                end
            end

            last_pos = pos;
            r = '{pos, vel[31:0], acc_out[31:0], ph, going_down, 1'b0};
            expected_q.push_back(r);
        endfunction

        // Compares one returned item with the oldest queued expectation.
        function void check_result(logic [M_DATA_W-1:0] d);
            tick_result_t got;
            tick_result_t want;
            bit           bad;

            got.position    = d[31:0];
            got.velocity    = d[63:32];
            got.accel       = d[95:64];
            got.phase       = phase_t'(d[97:96]);
            got.moving_down = d[98];
            got.halted      = d[99];

            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result item pos %h vel %h acc %h phase %0d",
                             $realtime, got.position, got.velocity, got.accel, got.phase);
                end
                return;
            end

            want = expected_q.pop_front();
            bad  = (got.position !== want.position) || (got.velocity !== want.velocity) ||
                   (got.accel !== want.accel) || (got.phase !== want.phase) ||
                   (got.moving_down !== want.moving_down) || (got.halted !== want.halted);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch, expected pos %h vel %h acc %h phase %0d down %0b halt %0b",
                             $realtime, want.position, want.velocity, want.accel,
                             want.phase, want.moving_down, want.halted);
                    $display("%0t:           actual   pos %h vel %h acc %h phase %0d down %0b halt %0b",
                             $realtime, got.position, got.velocity, got.accel,
                             got.phase, got.moving_down, got.halted);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // Block ports. Every input starts at a known value.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;    // [0] obstacle, rest zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;           // [31:0] position, [63:32] velocity,
                                              // [95:64] accel, [97:96] phase,
                                              // [98] moving_down, [99] halted
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    profile_scoreboard sb = new();

    // Idle rates in percent for each side; the main process changes them.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    // The main process bumps hold_seq to ask the receiver for a long hold-off.
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    reciprocating_trapezoid_profile_core #(
        .TIME_FRAC_BITS(TFRAC)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, or a long counted hold-off on request.
    // While it holds, the block parks two results and then stops taking ticks.
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Both handshakes are observed at the clock edge. A result always comes
    // after the edge that takes its tick, so the order of the two is harmless.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_tick(s_tdata[0]);
            end
        end
    end

    // Offers one tick and returns at the edge where it is taken. The valid is
    // only lowered when the sender idles, so back-to-back items keep it high.
    task automatic send_tick(input bit obstacle);
        if (src_idle_pct != 0 && $urandom_range(0, 49) == 0) begin
            // An occasional long gap lets idle time land on every step of the
            // block's multiply chain.
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 250)) @(posedge aclk);
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, obstacle};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // Stops offering and waits until every queued result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    // Writes all seven profile registers; call only while the block is idle.
    task automatic load_profile(input logic [31:0] sp, ep, vm, ac, at, ct, st);
        write_reg(CFG_START_POS, sp);
        write_reg(CFG_END_POS, ep);
        write_reg(CFG_VEL_MAX, vm);
        write_reg(CFG_ACCEL, ac);
        write_reg(CFG_ACCEL_TIME, at);
        write_reg(CFG_CRUISE_TIME, ct);
        write_reg(CFG_TIME_STEP, st);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Low end, high end or a fully random value, for the extreme settings.
    function automatic logic [31:0] edge_value(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(0, 2))
            0:       return lo;
            1:       return hi;
            default: return $urandom();
        endcase
    endfunction

    // Most settings are well-formed profiles whose phase times are small
    // multiples of the time step, often exact ones so that the phase borders
    // and the turnaround are hit on the dot. The rest are fully random or
    // built from the extremes of each register.
    task automatic load_random_profile();
        int          mode;
        int unsigned k_a;
        int unsigned k_c;
        logic [31:0] sp, ep, vm, ac, at, ct, st;

        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            st  = $urandom_range(1, 32'h0002_0000);
            k_a = $urandom_range(0, 6);
            k_c = $urandom_range(0, 6);
            at  = k_a * st;
            if ($urandom_range(0, 1)) begin
                at = at + $urandom_range(0, st - 1);
            end
            ct = k_c * st;
            if ($urandom_range(0, 1)) begin
                ct = ct + $urandom_range(0, st - 1);
            end
            sp = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
            ep = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
            vm = $urandom_range(0, 32'h0FFF_FFFF);
            ac = $urandom_range(0, 32'h0FFF_FFFF);
        end else if (mode < 85) begin
            sp = $urandom();
            ep = $urandom();
            vm = $urandom();
            ac = $urandom();
            at = $urandom();
            ct = $urandom();
            st = $urandom();
        end else begin
            sp = edge_value(32'h8000_0000, 32'h7FFF_FFFF);
            ep = edge_value(32'h8000_0000, 32'h7FFF_FFFF);
            vm = edge_value(32'h0000_0000, 32'h7FFF_FFFF);
            ac = edge_value(32'h0000_0000, 32'h7FFF_FFFF);
            at = edge_value(32'h0000_0000, 32'hFFFF_FFFF);
            ct = edge_value(32'h0000_0000, 32'hFFFF_FFFF);
            st = edge_value(32'h0000_0000, 32'hFFFF_FFFF);
        end
        load_profile(sp, ep, vm, ac, at, ct, st);
    endtask

    // Main sequence.
    initial begin
        int random_sent;
        int phase_no;
        int n;
        int drain_cycles;
        bit hold_done;

        random_sent = 0;
        phase_no    = 0;
        hold_done   = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. All registers zero: time never moves off zero.
        load_profile(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        repeat (2) send_tick(1'b0);

        // Extreme values, the start position most negative and the rest largest:
        // time saturates, the ramp distance clamps and the position saturates.
        wait_idle();
        load_profile(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (3) send_tick(1'b0);

        // No accelerate or cruise time: every tick turns around, with the
        // endpoints given the wrong way round.
        wait_idle();
        load_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                     32'h0, 32'h0, 32'h0000_0001);
        repeat (4) send_tick(1'b0);

        // Phase times exact multiples of the step: the ticks land on the end
        // of acceleration, the end of cruise and the total time, both ways.
        wait_idle();
        load_profile(32'hFFB0_0000, 32'h0030_0000, 32'h0020_0000, 32'h0010_0000,
                     32'h0000_2000, 32'h0000_1000, 32'h0000_1000);
        repeat (10) send_tick(1'b0);

        // Strong braking against a slow cruise: the velocity passes zero
        // before the turnaround.
        wait_idle();
        load_profile(32'h0000_0000, 32'h0040_0000, 32'h0010_0000, 32'h0080_0000,
                     32'h0001_0000, 32'h0001_0000, 32'h0000_8000);
        repeat (6) send_tick(1'b0);

        // Random part: a fresh profile for each run of ticks, first with the
        // receiver slow, then with the sender slow, then with neither idling.
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                src_idle_pct  = 20;
                sink_idle_pct = 88;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  = 88;
                sink_idle_pct = 20;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            wait_idle();
            load_random_profile();
            n = $urandom_range(20, 80);

            // Once, with nobody idling, the receiver holds off for a long time
            // while ticks keep coming, so the block backs up to its input.
            if (src_idle_pct == 0 && !hold_done) begin
                hold_seq  = hold_seq + 1;
                hold_done = 1'b1;
            end

            for (int i = 0; i < n; i++) begin
                // Once the sender also stops mid-run until all results are in.
                if (phase_no == 2 && i == n / 2) begin
                    wait_idle();
                end
                send_tick(1'b0);
            end
            random_sent = random_sent + n;
            phase_no    = phase_no + 1;
        end

        // The halt latches until reset, so it is exercised last: a few normal
        // ticks, then an obstacle, then further ticks with and without one.
        wait_idle();
        load_profile(32'hFF00_0000, 32'h0100_0000, 32'h0080_0000, 32'h0040_0000,
                     32'h0002_0000, 32'h0001_0000, 32'h0000_8000);
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        repeat (6) send_tick($urandom_range(0, 1));

        // Drain, then give the block time to show any stray result.
        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 200000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (300) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(50_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
